@@ design/nnis_pkg.sv @@
// Shared types and constants of the nearest-neighbor image scaler.
`timescale 1ns / 1ps
`default_nettype none
package nnis_pkg;

  // Field widths fixed by the item format
  localparam int COORD_W    = 10;
  localparam int PIX_IN_W   = 32;
  localparam int SRC_DIM_W  = 7;
  localparam int DST_DIM_W  = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int IN_TDATA_W = 56;

  // Scaled coordinate: product of a coordinate and a source size
  localparam int PROD_W = COORD_W + SRC_DIM_W;
  // Quotient is always below the source size, so it fits the source size width
  localparam int QUO_W  = SRC_DIM_W;
  localparam int STEP_W = $clog2(QUO_W);

  // Item kinds carried on in_tuser
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } cfg_reg_t;

  // Controller states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CHECK  = 7'b0000010,
    ST_MUL    = 7'b0000100,
    ST_DIV    = 7'b0001000,
    ST_ADDR   = 7'b0010000,
    ST_READ   = 7'b0100000,
    ST_RESULT = 7'b1000000
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch the accepted input beat
    logic mul;       // form the scaled products, load the dividers
    logic div_step;  // one restoring-division step on both axes
    logic addr;      // latch the frame store read address
    logic ram_re;    // read the frame store
    logic ram_we;    // write the loaded pixel
    logic emit;      // load the output register
    logic emit_oor;  // the emitted beat is out of range
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_fetch;  // captured item is a fetch
    logic in_range;  // captured coordinate lies inside its frame
    logic out_full;  // output register holds a beat that is not taken this cycle
  } sts_t;

endpackage
`default_nettype wire

@@ design/nnis_ram.sv @@
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module nnis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic             re,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

@@ design/nnis_ctrl.sv @@
// Sequencing state machine of the nearest-neighbor image scaler.
`timescale 1ns / 1ps
`default_nettype none
module nnis_ctrl
  import nnis_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              oor_r, oor_nxt;

  // State, step counter and range flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      oor_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      oor_r   <= oor_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    oor_nxt      = oor_r;
    cmd          = '0;
    cmd.emit_oor = oor_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!sts.in_range) begin
          oor_nxt   = 1'b1;
          state_nxt = ST_RESULT;
        end else if (sts.is_fetch) begin
          oor_nxt   = 1'b0;
          state_nxt = ST_MUL;
        end else begin
          cmd.ram_we = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_W'(QUO_W - 1)) begin
          state_nxt = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd.addr  = 1'b1;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.ram_re = 1'b1;
        state_nxt  = ST_RESULT;
      end
      ST_RESULT: begin
        // hold until the output register frees up
        if (!sts.out_full) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ design/nnis_dp.sv @@
// Datapath: configuration, range checks, scaling dividers, frame store, output register.
`timescale 1ns / 1ps
`default_nettype none
module nnis_dp
  import nnis_pkg::*;
#(
  parameter int MAX_SRC_WIDTH  = 64,
  parameter int MAX_SRC_HEIGHT = 64,
  parameter int PIXEL_BITS     = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic                  in_tuser,
  input  wire cmd_t                  cmd,
  output sts_t                       sts,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [PIX_IN_W-1:0]        out_tdata,
  output logic                       out_tuser
);

  localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SRC_DIM_W-1:0] src_w_r, src_h_r;
  logic [DST_DIM_W-1:0] dst_w_r, dst_h_r;

  logic                 func_r;
  logic [PIX_IN_W-1:0]  pix_r;
  logic [COORD_W-1:0]   x_r, y_r;

  logic [SRC_DIM_W-1:0] sw, sh;
  logic [DST_DIM_W-1:0] dw, dh;

  logic [PROD_W-1:0]    remx_r, remy_r, divx_r, divy_r;
  logic [QUO_W-1:0]     qx_r, qy_r;
  logic [AW-1:0]        addr_r;
  logic [31:0]          load_addr, fetch_addr;

  logic [PIXEL_BITS-1:0] ram_wdata, ram_rdata;
  logic [AW-1:0]         ram_addr;

  logic                 out_valid_r;
  logic [PIX_IN_W-1:0]  out_pix_r;
  logic                 out_oor_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= SRC_DIM_W'(64);
      src_h_r <= SRC_DIM_W'(64);
      dst_w_r <= DST_DIM_W'(64);
      dst_h_r <= DST_DIM_W'(64);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_SRC_WIDTH:  src_w_r <= cfg_data[SRC_DIM_W-1:0];
        REG_SRC_HEIGHT: src_h_r <= cfg_data[SRC_DIM_W-1:0];
        REG_DST_WIDTH:  dst_w_r <= cfg_data;
        REG_DST_HEIGHT: dst_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective sizes: zero acts as one, source sizes saturate at the store size
  always_comb begin
    if (src_w_r == '0) begin
      sw = SRC_DIM_W'(1);
    end else if (DST_DIM_W'(src_w_r) > DST_DIM_W'(MAX_SRC_WIDTH)) begin
      sw = SRC_DIM_W'(MAX_SRC_WIDTH);
    end else begin
      sw = src_w_r;
    end
    if (src_h_r == '0) begin
      sh = SRC_DIM_W'(1);
    end else if (DST_DIM_W'(src_h_r) > DST_DIM_W'(MAX_SRC_HEIGHT)) begin
      sh = SRC_DIM_W'(MAX_SRC_HEIGHT);
    end else begin
      sh = src_h_r;
    end
    dw = (dst_w_r == '0) ? DST_DIM_W'(1) : dst_w_r;
    dh = (dst_h_r == '0) ? DST_DIM_W'(1) : dst_h_r;
  end

  // Capture the input beat: pixel, x, y from the lowest bit up
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_tuser;
      pix_r  <= in_tdata[PIX_IN_W-1:0];
      x_r    <= in_tdata[PIX_IN_W +: COORD_W];
      y_r    <= in_tdata[PIX_IN_W+COORD_W +: COORD_W];
    end
  end

  // Range check against the frame that the item refers to
  always_comb begin
    sts.is_fetch = (func_r == FUNC_FETCH);
    if (func_r == FUNC_FETCH) begin
      sts.in_range = (DST_DIM_W'(x_r) < dw) && (DST_DIM_W'(y_r) < dh);
    end else begin
      sts.in_range = (x_r < COORD_W'(sw)) && (y_r < COORD_W'(sh));
    end
    sts.out_full = out_valid_r && !out_tready;
  end

  // Scale and divide: one quotient bit per step on both axes
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      remx_r <= PROD_W'(x_r) * PROD_W'(sw);
      remy_r <= PROD_W'(y_r) * PROD_W'(sh);
      divx_r <= PROD_W'(dw) << (QUO_W - 1);
      divy_r <= PROD_W'(dh) << (QUO_W - 1);
      qx_r   <= '0;
      qy_r   <= '0;
    end else if (cmd.div_step) begin
      if (remx_r >= divx_r) begin
        remx_r <= remx_r - divx_r;
        qx_r   <= {qx_r[QUO_W-2:0], 1'b1};
      end else begin
        qx_r   <= {qx_r[QUO_W-2:0], 1'b0};
      end
      if (remy_r >= divy_r) begin
        remy_r <= remy_r - divy_r;
        qy_r   <= {qy_r[QUO_W-2:0], 1'b1};
      end else begin
        qy_r   <= {qy_r[QUO_W-2:0], 1'b0};
      end
      divx_r <= divx_r >> 1;
      divy_r <= divy_r >> 1;
    end
  end

  // Row-major store addresses
  assign load_addr  = 32'(y_r) * 32'(MAX_SRC_WIDTH) + 32'(x_r);
  assign fetch_addr = 32'(qy_r) * 32'(MAX_SRC_WIDTH) + 32'(qx_r);

  always_ff @(posedge clk) begin
    if (cmd.addr) begin
      addr_r <= fetch_addr[AW-1:0];
    end
  end

  assign ram_addr  = cmd.ram_we ? load_addr[AW-1:0] : addr_r;
  assign ram_wdata = PIXEL_BITS'(pix_r);

  nnis_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_frame_store (
    .clk   (clk),
    .we    (cmd.ram_we),
    .re    (cmd.ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Output register: load on emit, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_oor_r <= cmd.emit_oor;
      out_pix_r <= cmd.emit_oor ? '0 : PIX_IN_W'(ram_rdata);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tuser  = out_oor_r;

endmodule
`default_nettype wire

@@ design/nearest_neighbor_image_scaler.sv @@
// Top level of the nearest-neighbor image scaler.
//
// Channels: a load beat (in_tuser = 0) writes pixel_in into the source frame
// store at (coord_x, coord_y); a fetch beat (in_tuser = 1) returns the source
// pixel at floor(x*src_w/dst_w), floor(y*src_h/dst_h) on the out_ channel.
// A coordinate outside its frame returns one beat with pixel zero and
// out_tuser set; an in-range load returns nothing.
// Configuration writes on cfg_ (index 0..3: src width, src height, dst width,
// dst height) are always ready; the user must make them while the block is idle,
// which the block does not enforce. Timing: one item at a time. An in-range
// load frees the input after the check state. out_tvalid rises after check and
// result for an out-of-range item, after check, multiply, divide, address, read
// and result for a fetch. A fetch runs the 7-step restoring divider (one
// quotient bit a cycle, both axes in parallel) and a registered frame store read.
// Reset: synchronous rst_n clears control and the output valid and sets all
// sizes to 64; frame store contents stay undefined until loaded.
// Stall: a result waits in the output register while out_tready is low, and
// the block holds its next result until that beat is taken.
`timescale 1ns / 1ps
`default_nettype none
module nearest_neighbor_image_scaler
  import nnis_pkg::*;
#(
  parameter int MAX_SRC_WIDTH  = 64,
  parameter int MAX_SRC_HEIGHT = 64,
  parameter int PIXEL_BITS     = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,   // pixel_in[31:0], coord_x[41:32], coord_y[51:42]
  input  wire logic                  in_tuser,   // func
  // result channel
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [PIX_IN_W-1:0]        out_tdata,  // pixel_out[31:0]
  output logic                       out_tuser   // out_of_range
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  nnis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  nnis_dp #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .PIXEL_BITS     (PIXEL_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
